FILE: design/bimm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimm_pkg: shared constants for the blocked int8 matrix multiply
// Element and accumulator widths, register widths and default sizes.
// ----------------------------------------------------------------------------
package bimm_pkg;

   // operand and accumulator widths
   localparam int ELEM_W    = 8;
   localparam int ACC_W     = 32;
   localparam int ROW_IDX_W = 3;

   // block pair count register
   localparam int K_W          = 7;
   localparam int MAX_K_BLOCKS = 64;

   // default block size
   localparam int DEF_BLOCK_DIM = 6;

   // accumulator store defaults
   localparam int DEF_RAM_DEPTH = DEF_BLOCK_DIM * DEF_BLOCK_DIM;

endpackage

FILE: design/bimm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimm_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bimm_ram
   import bimm_pkg::*;
#(
   parameter int WIDTH = ACC_W,
   parameter int DEPTH = DEF_RAM_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/blocked_int8_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blocked_int8_matrix_multiply: int8 block matrix multiply, int32 accumulate
// Collects BLOCK_DIM rows of an A and a B block, adds A*B into the
// accumulators and streams the sums out after k_blocks block pairs.
// ----------------------------------------------------------------------------
// Usage
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. req_a_row / req_b_row carry row r of the A and B blocks, signed
//   bytes packed low byte first. Rows arrive in order 0..BLOCK_DIM-1.
//   Rows 0..BLOCK_DIM-2 are only stored. The last row of a pair starts
//   a pass over the BLOCK_DIM*BLOCK_DIM accumulators, one dot product per
//   cycle on a shared bank of BLOCK_DIM 8x8 multipliers; busy stays high
//   while the pass runs and until its last product stage entry clears.
//   Output: on the pair that completes k_blocks pairs, the sums leave in
//   row-major order on consecutive cycles, each marked by rsp_valid for one
//   cycle, registered through the product stage and result registers;
//   rsp_last_of_block flags the final one. The receiver cannot stall.
//   Config: csr_wr_en writes k_blocks (0 acts as 1, values above
//   MAX_K_BLOCKS saturate); write only while idle.
//   Reset: synchronous; k_blocks returns to 1, row and pair counts clear and
//   the accumulators read as zero on the next block pair.
// ----------------------------------------------------------------------------
module blocked_int8_matrix_multiply
   import bimm_pkg::*;
#(
   parameter int BLOCK_DIM = DEF_BLOCK_DIM
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          start,
   output logic                          busy,
   input  logic [ELEM_W*BLOCK_DIM-1:0]   req_a_row,
   input  logic [ELEM_W*BLOCK_DIM-1:0]   req_b_row,
   // result channel
   output logic                          rsp_valid,
   output logic signed [ACC_W-1:0]       rsp_c_value,
   output logic [ROW_IDX_W-1:0]          rsp_c_row,
   output logic [ROW_IDX_W-1:0]          rsp_c_col,
   output logic                          rsp_last_of_block,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [K_W-1:0]                csr_wr_data
);

   localparam int ROW_W  = ELEM_W * BLOCK_DIM;
   localparam int IDX_W  = $clog2(BLOCK_DIM);
   localparam int CELLS  = BLOCK_DIM * BLOCK_DIM;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int PROD_W = 2 * ELEM_W;
   localparam int DOT_W  = PROD_W + IDX_W;
   localparam int K_CAP_INT = (MAX_K_BLOCKS < (1 << K_W) - 1) ? MAX_K_BLOCKS
                                                              : (1 << K_W) - 1;

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BLOCK_DIM - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
   localparam logic [K_W-1:0]    K_CAP     = K_W'(K_CAP_INT);

   // sequencer states
   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // control registers
   logic              state_ff, state_in;
   logic [K_W-1:0]    csr_k_ff;
   logic [IDX_W-1:0]  row_count_ff, row_count_in;
   logic [K_W-1:0]    pair_count_ff, pair_count_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              pass_first_ff, pass_first_in;
   logic              pass_emit_ff, pass_emit_in;

   // row stores
   logic [ROW_W-1:0]  a_rows_ff [BLOCK_DIM];
   logic [ROW_W-1:0]  b_rows_ff [BLOCK_DIM];

   // product stage
   logic signed [PROD_W-1:0] prod_ff [BLOCK_DIM];
   logic signed [PROD_W-1:0] prod_in [BLOCK_DIM];
   logic                     s1_valid_ff;
   logic [ADDR_W-1:0]        s1_addr_ff;
   logic [IDX_W-1:0]         s1_row_ff;
   logic [IDX_W-1:0]         s1_col_ff;
   logic                     s1_first_ff;
   logic                     s1_emit_ff;
   logic                     s1_last_ff;

   // accumulate stage
   logic signed [DOT_W-1:0]  dot;
   logic [ACC_W-1:0]         acc_base;
   logic [ACC_W-1:0]         acc_sum;
   logic [ACC_W-1:0]         ram_rd_data;

   // result registers
   logic                     rsp_valid_ff;
   logic                     rsp_last_ff;
   logic [ACC_W-1:0]         rsp_value_ff;
   logic [ROW_IDX_W-1:0]     rsp_row_ff;
   logic [ROW_IDX_W-1:0]     rsp_col_ff;

   logic              accept;
   logic [K_W-1:0]    k_floor;
   logic [K_W-1:0]    eff_k;
   logic [K_W-1:0]    pair_next;
   logic              block_done;
   logic [ROW_W-1:0]  a_sel;

   // handshake
   assign busy   = (state_ff == ST_RUN) || s1_valid_ff;
   assign accept = start && !busy;

   // effective block pair count
   assign k_floor    = (csr_k_ff == '0) ? K_W'(1) : csr_k_ff;
   assign eff_k      = (k_floor > K_CAP) ? K_CAP : k_floor;
   assign pair_next  = pair_count_ff + K_W'(1);
   assign block_done = (pair_next >= eff_k);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      row_count_in  = row_count_ff;
      pair_count_in = pair_count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      addr_in       = addr_ff;
      pass_first_in = pass_first_ff;
      pass_emit_in  = pass_emit_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (row_count_ff == LAST_IDX) begin
                  row_count_in  = '0;
                  state_in      = ST_RUN;
                  i_in          = '0;
                  j_in          = '0;
                  addr_in       = '0;
                  pass_first_in = (pair_count_ff == '0);
                  pass_emit_in  = block_done;
                  pair_count_in = block_done ? '0 : pair_next;
               end else begin
                  row_count_in = row_count_ff + IDX_W'(1);
               end
            end
         end
         ST_RUN: begin
            addr_in = addr_ff + ADDR_W'(1);
            if (j_ff == LAST_IDX) begin
               j_in = '0;
               i_in = i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         csr_k_ff      <= K_W'(1);
         row_count_ff  <= '0;
         pair_count_ff <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         addr_ff       <= '0;
         pass_first_ff <= 1'b0;
         pass_emit_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_count_ff  <= row_count_in;
         pair_count_ff <= pair_count_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         addr_ff       <= addr_in;
         pass_first_ff <= pass_first_in;
         pass_emit_ff  <= pass_emit_in;
         if (csr_wr_en) begin
            csr_k_ff <= csr_wr_data;
         end
      end
   end

   // row capture
   always_ff @(posedge clock) begin
      if (accept) begin
         a_rows_ff[row_count_ff] <= req_a_row;
         b_rows_ff[row_count_ff] <= req_b_row;
      end
   end

   // shared multiplier bank: row i of A against column j of B
   assign a_sel = a_rows_ff[i_ff];
   always_comb begin
      for (int m = 0; m < BLOCK_DIM; m++) begin
         prod_in[m] = PROD_W'($signed(a_sel[m*ELEM_W +: ELEM_W]))
                    * PROD_W'($signed(b_rows_ff[m][j_ff*ELEM_W +: ELEM_W]));
      end
   end

   // product stage registers
   always_ff @(posedge clock) begin
      for (int m = 0; m < BLOCK_DIM; m++) begin
         prod_ff[m] <= prod_in[m];
      end
      s1_addr_ff  <= addr_ff;
      s1_row_ff   <= i_ff;
      s1_col_ff   <= j_ff;
      s1_first_ff <= pass_first_ff;
      s1_emit_ff  <= pass_emit_ff;
      s1_last_ff  <= (addr_ff == LAST_ADDR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= (state_ff == ST_RUN);
      end
   end

   // dot product and accumulate; first pair of a block starts from zero
   always_comb begin
      dot = '0;
      for (int m = 0; m < BLOCK_DIM; m++) begin
         dot = dot + DOT_W'(prod_ff[m]);
      end
   end

   assign acc_base = s1_first_ff ? '0 : ram_rd_data;
   assign acc_sum  = acc_base + ACC_W'(dot);

   // accumulator store
   bimm_ram #(
      .WIDTH (ACC_W),
      .DEPTH (CELLS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (acc_sum),
      .rd_en   (state_ff == ST_RUN),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff && s1_emit_ff;
         rsp_last_ff  <= s1_valid_ff && s1_emit_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_emit_ff) begin
         rsp_value_ff <= acc_sum;
         rsp_row_ff   <= ROW_IDX_W'(s1_row_ff);
         rsp_col_ff   <= ROW_IDX_W'(s1_col_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_c_value       = $signed(rsp_value_ff);
   assign rsp_c_row         = rsp_row_ff;
   assign rsp_c_col         = rsp_col_ff;
   assign rsp_last_of_block = rsp_last_ff;

   // checks
   a_last_has_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_block |-> rsp_valid)
      else $error("last flag without a result");

   a_block_contiguous : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_block) |=> rsp_valid)
      else $error("gap inside a result block");

   a_gap_after_block : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_block) |=> !rsp_valid)
      else $error("result right after end of block");

   a_last_row_runs : assert property (@(posedge clock) disable iff (reset)
      (accept && (row_count_ff == LAST_IDX)) |=> (state_ff == ST_RUN))
      else $error("pass did not start on last row");

   a_run_row_cleared : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (row_count_ff == '0))
      else $error("row count not cleared during pass");

endmodule
